/* src/rfd_pkg.sv */
// Shared types and constants for the remote frame deframer.
package rfd_pkg;

	localparam int PAYLOAD_BYTES = 16;
	localparam int IDX_W = $clog2(PAYLOAD_BYTES);

	localparam logic [7:0] SYNC_A = 8'hAA;
	localparam logic [7:0] SYNC_B = 8'h55;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_SYNC,
		PH_PAYLOAD,
		PH_TRAIL_A,
		PH_TRAIL_B
	} phase_t;

	typedef struct packed {
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic signed [15:0] left_x;
		logic signed [15:0] left_y;
		logic signed [15:0] knob_one;
		logic signed [15:0] knob_two;
		logic signed [15:0] knob_three;
		logic [15:0]        key_bits;
	} frame_t;

	typedef struct packed {
		phase_t phase;
		logic   emit;
	} parse_status_t;

endpackage

/* src/remote_frame_deframer.sv */
// Top level of the remote frame deframer: input register, parser, result register.
//
//  channel | signals                           | dir | word
//  rx      | rx_valid, rx_ready, rx_byte       | in  | one received byte
//  frame   | frame_valid, frame_ready, fields  | out | seven channels and key word
//
// One byte per cycle unless a held frame word stalls it; a frame word is loaded
// into the result register as its last trailer byte leaves the input register.
// Reset returns the parser to header hunt; the payload store is not cleared.
// A held frame word only stalls a byte that would produce another frame;
// other bytes keep flowing.
module remote_frame_deframer
	import rfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_ready,
	input  logic [7:0]         rx_byte,
	output logic               frame_valid,
	input  logic               frame_ready,
	output logic signed [15:0] right_x,
	output logic signed [15:0] right_y,
	output logic signed [15:0] left_x,
	output logic signed [15:0] left_y,
	output logic signed [15:0] knob_one,
	output logic signed [15:0] knob_two,
	output logic signed [15:0] knob_three,
	output logic [15:0]        key_bits
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          advance;
	parse_status_t status;
	frame_t        frame_d;
	frame_t        frame_q;
	logic          frame_valid_q;

	assign advance  = valid_s1 && (!status.emit || !frame_valid_q || frame_ready);
	assign rx_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	rfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.status  (status),
		.frame   (frame_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
		end else if (advance && status.emit) begin
			frame_valid_q <= 1'b1;
		end else if (frame_ready) begin
			frame_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && status.emit) begin
			frame_q <= frame_d;
		end
	end

	assign frame_valid = frame_valid_q;
	assign right_x     = frame_q.right_x;
	assign right_y     = frame_q.right_y;
	assign left_x      = frame_q.left_x;
	assign left_y      = frame_q.left_y;
	assign knob_one    = frame_q.knob_one;
	assign knob_two    = frame_q.knob_two;
	assign knob_three  = frame_q.knob_three;
	assign key_bits    = frame_q.key_bits;

`ifndef SYNTHESIS
	a_emit_in_trailer: assert property (@(posedge clk) disable iff (!arst_n)
		status.emit |-> status.phase == PH_TRAIL_B)
		else $error("emit outside trailer phase");

	a_rose_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(frame_valid_q) |-> $past(advance && status.emit))
		else $error("frame word appeared without a completed trailer");

	a_stall_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> valid_s1 && status.emit && frame_valid_q)
		else $error("input stalled without a pending frame collision");

	a_phase_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && status.emit |=> status.phase == PH_HUNT)
		else $error("parser not back to hunt after a frame");
`endif

endmodule

/* src/rfd_parser.sv */
// Phase tracker, payload store and frame assembly for the deframer.
module rfd_parser
	import rfd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    rx_byte,
	output parse_status_t status,
	output frame_t        frame
);

	phase_t           phase_q, phase_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             store_we;
	logic [7:0]       store_q [PAYLOAD_BYTES];

	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		unique case (phase_q)
			PH_HUNT: begin
				phase_d = (rx_byte == SYNC_A) ? PH_SYNC : PH_HUNT;
			end
			PH_SYNC: begin
				if (rx_byte == SYNC_B) begin
					phase_d = PH_PAYLOAD;
					idx_d   = '0;
				end else if (rx_byte != SYNC_A) begin
					phase_d = PH_HUNT;
				end
			end
			PH_PAYLOAD: begin
				if (idx_q == IDX_W'(PAYLOAD_BYTES - 1)) begin
					phase_d = PH_TRAIL_A;
					idx_d   = '0;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			PH_TRAIL_A: begin
				phase_d = (rx_byte == SYNC_B) ? PH_TRAIL_B : PH_HUNT;
			end
			PH_TRAIL_B: begin
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_comb begin
		store_we = 1'b0;
		status.phase = phase_q;
		status.emit  = 1'b0;
		unique case (phase_q)
			PH_PAYLOAD: begin
				store_we = 1'b1;
			end
			PH_TRAIL_B: begin
				status.emit = (rx_byte == SYNC_A);
			end
			default: begin
				store_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			idx_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && store_we) begin
			store_q[idx_q] <= rx_byte;
		end
	end

	// little-endian channels, key word big-endian
	assign frame.right_x    = {store_q[1], store_q[0]};
	assign frame.right_y    = {store_q[3], store_q[2]};
	assign frame.left_x     = {store_q[5], store_q[4]};
	assign frame.left_y     = {store_q[7], store_q[6]};
	assign frame.knob_one   = {store_q[9], store_q[8]};
	assign frame.knob_two   = {store_q[11], store_q[10]};
	assign frame.knob_three = {store_q[13], store_q[12]};
	assign frame.key_bits   = {store_q[14], store_q[15]};

endmodule

/* tb/tb_top.sv */
// Testbench for remote_frame_deframer: byte stimulus, frame prediction and checking.
`timescale 1ns / 1ps

module tb_top;
	import rfd_pkg::*;

	localparam int RUN_BYTES   = 750;
	localparam int CYCLE_LIMIT = 250000;
	localparam int TAIL_CYCLES = 8;

	typedef enum int {
		SEQ_GOOD,
		SEQ_BAD_TRAIL_A,
		SEQ_BAD_TRAIL_B,
		SEQ_BAD_HEAD,
		SEQ_NOISE
	} seq_kind_t;

	// Tracks the parser state and the frames it should produce.
	class frame_tracker;
		phase_t     phase;
		int         slot;
		logic [7:0] store [PAYLOAD_BYTES];
		frame_t     pending_frames [$];
		int         errors;
		int         frames_seen;

		function new();
			phase       = PH_HUNT;
			slot        = 0;
			errors      = 0;
			frames_seen = 0;
		endfunction

		function void take_byte(logic [7:0] b);
			logic [127:0] bits;
			case (phase)
				PH_HUNT: begin
					phase = (b == SYNC_A) ? PH_SYNC : PH_HUNT;
				end
				PH_SYNC: begin
					if (b == SYNC_B) begin
						slot  = 0;
						phase = PH_PAYLOAD;
					end else if (b != SYNC_A) begin
						phase = PH_HUNT;
					end
				end
				PH_PAYLOAD: begin
					store[slot] = b;
					if (slot == PAYLOAD_BYTES - 1) begin
						slot  = 0;
						phase = PH_TRAIL_A;
					end else begin
						slot++;
					end
				end
				PH_TRAIL_A: begin
					phase = (b == SYNC_B) ? PH_TRAIL_B : PH_HUNT;
				end
				PH_TRAIL_B: begin
					if (b == SYNC_A) begin
						for (int ch = 0; ch < 7; ch++)
							bits[127 - 16 * ch -: 16] = {store[2 * ch + 1], store[2 * ch]};
						bits[15:0] = {store[14], store[15]};
						pending_frames.push_back(frame_t'(bits));
					end
					phase = PH_HUNT;
				end
				default: begin
					phase = PH_HUNT;
				end
			endcase
		endfunction

		function void match_frame(frame_t got);
			frame_t       want;
			logic [127:0] wb;
			logic [127:0] gb;
			string        names [8];
			names = '{"right_x", "right_y", "left_x", "left_y",
				"knob_one", "knob_two", "knob_three", "key_bits"};
			if (pending_frames.size() == 0) begin
				$display("%0t: unexpected frame word %h", $time, got);
				errors++;
				return;
			end
			want = pending_frames.pop_front();
			frames_seen++;
			wb = want;
			gb = got;
			for (int k = 0; k < 8; k++)
				if (gb[127 - 16 * k -: 16] !== wb[127 - 16 * k -: 16]) begin
					$display("%0t: %s expected %h actual %h", $time, names[k],
						wb[127 - 16 * k -: 16], gb[127 - 16 * k -: 16]);
					errors++;
				end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               rx_valid;
	logic               rx_ready;
	logic [7:0]         rx_byte;
	logic               frame_valid;
	logic               frame_ready;
	logic signed [15:0] right_x;
	logic signed [15:0] right_y;
	logic signed [15:0] left_x;
	logic signed [15:0] left_y;
	logic signed [15:0] knob_one;
	logic signed [15:0] knob_two;
	logic signed [15:0] knob_three;
	logic [15:0]        key_bits;

	frame_tracker tracker;
	bit           no_idle;
	int           cycles;
	int           bytes_sent;
	int           seq_count [5];

	remote_frame_deframer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_ready    (rx_ready),
		.rx_byte     (rx_byte),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.right_x     (right_x),
		.right_y     (right_y),
		.left_x      (left_x),
		.left_y      (left_y),
		.knob_one    (knob_one),
		.knob_two    (knob_two),
		.knob_three  (knob_three),
		.key_bits    (key_bits)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] payload_byte();
		logic [7:0] edges [6];
		edges = '{8'h00, 8'hFF, 8'h80, 8'h7F, SYNC_A, SYNC_B};
		if ($urandom_range(0, 7) == 0)
			return edges[$urandom_range(0, 5)];
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] byte_other_than(logic [7:0] a, logic [7:0] b);
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v == a || v == b);
		return v;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (!rx_ready);
		tracker.take_byte(b);
		bytes_sent++;
	endtask

	task automatic hold_until_drained();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_frames.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_header();
		send_byte(SYNC_A);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) send_byte(SYNC_A);
		send_byte(SYNC_B);
	endtask

	task automatic send_sequence(input seq_kind_t kind);
		seq_count[kind]++;
		case (kind)
			SEQ_BAD_HEAD: begin
				send_byte(SYNC_A);
				send_byte(byte_other_than(SYNC_A, SYNC_B));
			end
			SEQ_NOISE: begin
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
			end
			default: begin
				send_header();
				repeat (PAYLOAD_BYTES) send_byte(payload_byte());
				if (kind == SEQ_BAD_TRAIL_A) begin
					send_byte(byte_other_than(SYNC_B, SYNC_B));
				end else begin
					send_byte(SYNC_B);
					if (kind == SEQ_BAD_TRAIL_B)
						send_byte(byte_other_than(SYNC_A, SYNC_A));
					else
						send_byte(SYNC_A);
				end
			end
		endcase
	endtask

	// cycle count, watchdog and calm stretches
	initial begin
		cycles  = 0;
		no_idle = 1'b0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles % 200 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if (cycles >= CYCLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// frame receiver with random back-pressure
	initial begin
		int stall_left;
		stall_left  = 0;
		frame_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (frame_valid && frame_ready)
				tracker.match_frame(frame_t'({right_x, right_y, left_x, left_y,
					knob_one, knob_two, knob_three, key_bits}));
			if (stall_left > 0) begin
				frame_ready <= 1'b0;
				stall_left--;
			end else begin
				frame_ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	initial begin
		logic [7:0] directed [$];
		seq_kind_t  kind;
		int         r;
		bit         drained_mid;

		tracker     = new();
		bytes_sent  = 0;
		drained_mid = 1'b0;
		seq_count   = '{default: 0};
		arst_n      = 1'b0;
		rx_valid    = 1'b0;
		rx_byte     = 8'h00;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray byte, broken header, repeated header byte, extreme payload
		directed = '{8'h00, SYNC_A, 8'h12, SYNC_A, SYNC_A, SYNC_B,
			8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'hFF,
			SYNC_A, SYNC_B, SYNC_B, SYNC_A, 8'h01, 8'h80, 8'h0F, 8'hF0,
			SYNC_B, SYNC_A};
		foreach (directed[i])
			send_byte(directed[i]);
		hold_until_drained();

		while (bytes_sent < RUN_BYTES) begin
			r = $urandom_range(0, 19);
			if (r < 13)
				kind = SEQ_GOOD;
			else if (r < 15)
				kind = SEQ_BAD_TRAIL_A;
			else if (r < 17)
				kind = SEQ_BAD_TRAIL_B;
			else if (r < 18)
				kind = SEQ_BAD_HEAD;
			else
				kind = SEQ_NOISE;
			send_sequence(kind);
			if (!drained_mid && bytes_sent > RUN_BYTES / 2) begin
				hold_until_drained();
				drained_mid = 1'b1;
			end
		end

		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (tracker.pending_frames.size() != 0) begin
			$display("%0t: %0d frame words never arrived", $time,
				tracker.pending_frames.size());
			tracker.errors++;
		end
		$display("Sent %0d bytes; %0d frame words checked.", bytes_sent,
			tracker.frames_seen);
		$display("Sequences: %0d good, %0d/%0d bad trailer, %0d bad header, %0d noise.",
			seq_count[SEQ_GOOD], seq_count[SEQ_BAD_TRAIL_A], seq_count[SEQ_BAD_TRAIL_B],
			seq_count[SEQ_BAD_HEAD], seq_count[SEQ_NOISE]);
		if (tracker.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
